### rtl/first_fit_heap_allocator_defines.svh
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define FFHA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   localparam int DESCRIPTORS_DEF = 64;
   localparam int ADDR_BITS_DEF   = 32;
   localparam int SIZE_W          = 32;
   localparam int ALIGN_W         = 17;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NO_FIT  = 2'd1,
      STS_NO_DESC = 2'd2,
      STS_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_HEAP_SIZE = 1'b1;

   typedef struct packed {
      logic               start;
      logic [SIZE_W-1:0]  dividend;
      logic [ALIGN_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic               done;
      logic [ALIGN_W-1:0] rem;
   } rem_rsp_type;

endpackage

`default_nettype wire

### rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over a pool of region descriptors with free coalescing
// ----------------------------------------------------------------------------
// latency of an allocation grows with the free regions scanned; that of a
//   free grows with the outstanding blocks and free regions scanned, and with
//   each free region walked and each merge during coalescing
// one item at a time; the serial remainder unit and the walk through the
//   descriptor ram, whose reads are registered, dominate the latency
// reset is synchronous; per-entry valid flops give the init values at once,
//   so there is no clearing pass; a register write re-inits the pool
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
   parameter int DESCRIPTORS = ffha_pkg::DESCRIPTORS_DEF,
   parameter int ADDR_BITS   = ffha_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_type,
   input  wire logic [ffha_pkg::SIZE_W-1:0]         req_size,
   input  wire logic [ffha_pkg::ALIGN_W-1:0]        req_align,
   input  wire logic [ffha_pkg::SIZE_W-1:0]         req_free_addr,
   // result channel
   output logic                                     rsp_valid,
   output logic      [ffha_pkg::SIZE_W-1:0]         rsp_alloc_addr,
   output logic      [1:0]                          rsp_status,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [ffha_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [ffha_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [ffha_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready
);
   import ffha_pkg::*;

   localparam int IW = $clog2(DESCRIPTORS);
   localparam int LW = $clog2(DESCRIPTORS + 1);
   localparam int SW = (ADDR_BITS > SIZE_W + 1) ? ADDR_BITS : SIZE_W + 1;
   localparam int CW = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;
   localparam int EW = ADDR_BITS + SIZE_W + LW;
   localparam logic [LW-1:0] NONE = LW'(DESCRIPTORS);

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [SIZE_W-1:0]    size;
      logic [LW-1:0]        link;
   } desc_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_NEED,
      S_A_RD, S_A_CHK, S_SP_RD, S_SP_CHK, S_A_BASE, S_A_SIZE, S_A_REL, S_A_GIVE,
      S_F_RD, S_F_CHK, S_F_UNLINK,
      S_I_RD, S_I_CHK, S_I_CUR, S_I_PRV,
      S_C_RD, S_C_LD, S_C_CHK, S_C_NX, S_C_MERGE, S_C_SPARE
   } state_type;

   state_type             state_ff, state_in;
   req_kind_type          kind_ff, kind_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ALIGN_W-1:0]    align_ff, align_in;
   logic [SIZE_W-1:0]     faddr_ff, faddr_in;
   logic [SW-1:0]         tmp_ff, tmp_in;
   logic [SIZE_W:0]       need_ff, need_in;
   logic [LW-1:0]         cur_ff, cur_in;
   logic [LW-1:0]         prv_ff, prv_in;
   logic [LW-1:0]         nx_ff, nx_in;
   desc_type              ent_ff, ent_in;
   desc_type              pent_ff, pent_in;
   desc_type              nent_ff, nent_in;
   logic [SIZE_W-1:0]     addr_ff, addr_in;
   logic [LW-1:0]         free_head_ff, free_head_in;
   logic [LW-1:0]         out_head_ff, out_head_in;
   logic [LW-1:0]         spare_head_ff, spare_head_in;
   logic [SIZE_W-1:0]     heap_base_ff, heap_base_in;
   logic [SIZE_W-1:0]     heap_size_ff, heap_size_in;
   logic [DESCRIPTORS-1:0] vld_ff, vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]     rsp_addr_ff, rsp_addr_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [IW-1:0]         rd_idx_ff;
   logic                  vld_rd_ff;

   // ram, alu and remainder unit hookup
   logic [IW-1:0]         rd_addr;
   logic                  wr_en;
   logic [IW-1:0]         wr_idx;
   desc_type              wr_ent;
   logic [EW-1:0]         ram_rdata;
   desc_type              init_ent;
   desc_type              rd_ent;
   alu_op_type            alu_op;
   logic [SW-1:0]         alu_a, alu_b, alu_res;
   logic                  alu_borrow;
   rem_req_type           rem_req;
   rem_rsp_type           rem_rsp;

   logic                  csr_wr;
   logic [SIZE_W-1:0]     new_size;
   logic [CW-1:0]         hb_ext;
   logic [CW-1:0]         base_ext;
   logic [CW-1:0]         rd_base_ext;
   logic [SIZE_W:0]       need_sum;

   ffha_ram #(
      .WIDTH (EW),
      .DEPTH (DESCRIPTORS)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   ffha_alu #(
      .W (SW)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   ffha_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   // value an entry holds right after init, used while its valid flop is clear
   always_comb begin
      hb_ext        = CW'(heap_base_ff);
      init_ent.base = '0;
      init_ent.size = '0;
      if (rd_idx_ff == IW'(DESCRIPTORS - 1)) begin
         init_ent.link = NONE;
      end else begin
         init_ent.link = LW'(rd_idx_ff) + LW'(1);
      end
      if (rd_idx_ff == '0 && heap_size_ff != '0) begin
         init_ent.base = hb_ext[ADDR_BITS-1:0];
         init_ent.size = heap_size_ff;
         init_ent.link = NONE;
      end
   end

   assign rd_ent = vld_rd_ff ? desc_type'(ram_rdata) : init_ent;

   assign csr_wr   = psel && penable && pwrite;
   assign new_size = (paddr[2] == CSR_HEAP_SIZE) ? pwdata : heap_size_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      faddr_in      = faddr_ff;
      tmp_in        = tmp_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      prv_in        = prv_ff;
      nx_in         = nx_ff;
      ent_in        = ent_ff;
      pent_in       = pent_ff;
      nent_in       = nent_ff;
      addr_in       = addr_ff;
      free_head_in  = free_head_ff;
      out_head_in   = out_head_ff;
      spare_head_in = spare_head_ff;
      heap_base_in  = heap_base_ff;
      heap_size_in  = heap_size_ff;
      vld_in        = vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      rd_addr       = cur_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_idx        = cur_ff[IW-1:0];
      wr_ent        = ent_ff;
      alu_op        = ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;
      need_sum      = '0;
      base_ext      = '0;
      rd_base_ext   = '0;

      rem_req.start    = 1'b0;
      rem_req.dividend = req_size;
      rem_req.divisor  = (req_align == '0) ? ALIGN_W'(1) : req_align;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind_type'(req_type);
               size_in  = req_size;
               align_in = rem_req.divisor;
               faddr_in = req_free_addr;
               prv_in   = NONE;
               if (req_kind_type'(req_type) == REQ_FREE) begin
                  cur_in   = out_head_ff;
                  state_in = S_F_RD;
               end else begin
                  rem_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end

         // round-up pad: align - rem, or nothing when already aligned
         S_DIV: begin
            alu_op = ALU_SUB;
            alu_a  = SW'(align_ff);
            alu_b  = SW'(rem_rsp.rem);
            if (rem_rsp.done) begin
               tmp_in   = (rem_rsp.rem == '0) ? '0 : alu_res;
               state_in = S_NEED;
            end
         end

         S_NEED: begin
            alu_op   = ALU_ADD;
            alu_a    = SW'(size_ff);
            alu_b    = tmp_ff;
            need_sum = alu_res[SIZE_W:0];
            need_in  = need_sum;
            cur_in   = free_head_ff;
            prv_in   = NONE;
            if (need_sum == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STS_NO_FIT;
               state_in      = S_IDLE;
            end else begin
               state_in = S_A_RD;
            end
         end

         // first-fit walk of the free list
         S_A_RD: begin
            if (cur_ff == NONE) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STS_NO_FIT;
               state_in      = S_IDLE;
            end else begin
               state_in = S_A_CHK;
            end
         end

         S_A_CHK: begin
            alu_op = ALU_SUB;
            alu_a  = SW'(rd_ent.size);
            alu_b  = SW'(need_ff);
            if (alu_borrow) begin
               prv_in   = cur_ff;
               pent_in  = rd_ent;
               cur_in   = rd_ent.link;
               state_in = S_A_RD;
            end else begin
               ent_in   = rd_ent;
               state_in = S_SP_RD;
            end
         end

         S_SP_RD: begin
            nx_in   = spare_head_ff;
            rd_addr = spare_head_ff[IW-1:0];
            if (spare_head_ff == NONE) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STS_NO_DESC;
               state_in      = S_IDLE;
            end else begin
               state_in = S_SP_CHK;
            end
         end

         // record the new block on the outstanding list
         S_SP_CHK: begin
            base_ext      = CW'(ent_ff.base);
            spare_head_in = rd_ent.link;
            wr_en         = 1'b1;
            wr_idx        = nx_ff[IW-1:0];
            wr_ent.base   = ent_ff.base;
            wr_ent.size   = need_ff[SIZE_W-1:0];
            wr_ent.link   = out_head_ff;
            out_head_in   = nx_ff;
            addr_in       = base_ext[SIZE_W-1:0];
            state_in      = S_A_BASE;
         end

         S_A_BASE: begin
            alu_op      = ALU_ADD;
            alu_a       = SW'(ent_ff.base);
            alu_b       = SW'(need_ff);
            ent_in.base = alu_res[ADDR_BITS-1:0];
            state_in    = S_A_SIZE;
         end

         S_A_SIZE: begin
            alu_op      = ALU_SUB;
            alu_a       = SW'(ent_ff.size);
            alu_b       = SW'(need_ff);
            ent_in.size = alu_res[SIZE_W-1:0];
            if (alu_res[SIZE_W-1:0] != '0) begin
               wr_en         = 1'b1;
               wr_ent.base   = ent_ff.base;
               wr_ent.size   = alu_res[SIZE_W-1:0];
               wr_ent.link   = ent_ff.link;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = addr_ff;
               rsp_status_in = STS_OK;
               state_in      = S_IDLE;
            end else begin
               state_in = S_A_REL;
            end
         end

         // region used up: unlink it
         S_A_REL: begin
            if (prv_ff != NONE) begin
               wr_en       = 1'b1;
               wr_idx      = prv_ff[IW-1:0];
               wr_ent.base = pent_ff.base;
               wr_ent.size = pent_ff.size;
               wr_ent.link = ent_ff.link;
            end else begin
               free_head_in = ent_ff.link;
            end
            state_in = S_A_GIVE;
         end

         S_A_GIVE: begin
            wr_en         = 1'b1;
            wr_ent.base   = '0;
            wr_ent.size   = '0;
            wr_ent.link   = spare_head_ff;
            spare_head_in = cur_ff;
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = addr_ff;
            rsp_status_in = STS_OK;
            state_in      = S_IDLE;
         end

         // look up the block on the outstanding list
         S_F_RD: begin
            if (cur_ff == NONE) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STS_UNKNOWN;
               state_in      = S_IDLE;
            end else begin
               state_in = S_F_CHK;
            end
         end

         S_F_CHK: begin
            rd_base_ext = CW'(rd_ent.base);
            if (rd_base_ext == CW'(faddr_ff)) begin
               ent_in   = rd_ent;
               state_in = S_F_UNLINK;
            end else begin
               prv_in   = cur_ff;
               pent_in  = rd_ent;
               cur_in   = rd_ent.link;
               state_in = S_F_RD;
            end
         end

         S_F_UNLINK: begin
            if (prv_ff != NONE) begin
               wr_en       = 1'b1;
               wr_idx      = prv_ff[IW-1:0];
               wr_ent.base = pent_ff.base;
               wr_ent.size = pent_ff.size;
               wr_ent.link = ent_ff.link;
            end else begin
               out_head_in = ent_ff.link;
            end
            nx_in    = free_head_ff;
            prv_in   = NONE;
            state_in = S_I_RD;
         end

         // address-ordered insert point in the free list
         S_I_RD: begin
            rd_addr = nx_ff[IW-1:0];
            if (nx_ff == NONE) begin
               state_in = S_I_CUR;
            end else begin
               state_in = S_I_CHK;
            end
         end

         S_I_CHK: begin
            alu_op = ALU_SUB;
            alu_a  = SW'(rd_ent.base);
            alu_b  = SW'(ent_ff.base);
            if (alu_borrow) begin
               prv_in   = nx_ff;
               pent_in  = rd_ent;
               nx_in    = rd_ent.link;
               state_in = S_I_RD;
            end else begin
               state_in = S_I_CUR;
            end
         end

         S_I_CUR: begin
            wr_en       = 1'b1;
            wr_ent.base = ent_ff.base;
            wr_ent.size = ent_ff.size;
            wr_ent.link = nx_ff;
            state_in    = S_I_PRV;
         end

         S_I_PRV: begin
            if (prv_ff != NONE) begin
               wr_en       = 1'b1;
               wr_idx      = prv_ff[IW-1:0];
               wr_ent.base = pent_ff.base;
               wr_ent.size = pent_ff.size;
               wr_ent.link = cur_ff;
               cur_in      = free_head_ff;
            end else begin
               free_head_in = cur_ff;
            end
            state_in = S_C_RD;
         end

         // coalesce pass from the head of the free list
         S_C_RD: begin
            state_in = S_C_LD;
         end

         S_C_LD: begin
            ent_in   = rd_ent;
            state_in = S_C_CHK;
         end

         S_C_CHK: begin
            rd_addr = ent_ff.link[IW-1:0];
            nx_in   = ent_ff.link;
            if (ent_ff.link == NONE) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STS_OK;
               state_in      = S_IDLE;
            end else begin
               state_in = S_C_NX;
            end
         end

         S_C_NX: begin
            alu_op  = ALU_ADD;
            alu_a   = SW'(ent_ff.base);
            alu_b   = SW'(ent_ff.size);
            nent_in = rd_ent;
            if (alu_res[ADDR_BITS-1:0] == rd_ent.base) begin
               state_in = S_C_MERGE;
            end else begin
               cur_in   = nx_ff;
               ent_in   = rd_ent;
               state_in = S_C_CHK;
            end
         end

         S_C_MERGE: begin
            alu_op      = ALU_ADD;
            alu_a       = SW'(ent_ff.size);
            alu_b       = SW'(nent_ff.size);
            ent_in.size = alu_res[SIZE_W-1:0];
            ent_in.link = nent_ff.link;
            wr_en       = 1'b1;
            wr_ent.base = ent_ff.base;
            wr_ent.size = alu_res[SIZE_W-1:0];
            wr_ent.link = nent_ff.link;
            state_in    = S_C_SPARE;
         end

         S_C_SPARE: begin
            wr_en         = 1'b1;
            wr_idx        = nx_ff[IW-1:0];
            wr_ent.base   = '0;
            wr_ent.size   = '0;
            wr_ent.link   = spare_head_ff;
            spare_head_in = nx_ff;
            state_in      = S_C_CHK;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         vld_in[wr_idx] = 1'b1;
      end

      // register write re-inits the whole pool
      if (csr_wr) begin
         if (paddr[2] == CSR_HEAP_SIZE) begin
            heap_size_in = pwdata;
         end else begin
            heap_base_in = pwdata;
         end
         vld_in        = '0;
         out_head_in   = NONE;
         free_head_in  = (new_size == '0) ? NONE : '0;
         spare_head_in = (new_size == '0) ? '0 : LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= NONE;
         out_head_ff   <= NONE;
         spare_head_ff <= '0;
         heap_base_ff  <= '0;
         heap_size_ff  <= '0;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         kind_ff       <= REQ_ALLOC;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         out_head_ff   <= out_head_in;
         spare_head_ff <= spare_head_in;
         heap_base_ff  <= heap_base_in;
         heap_size_ff  <= heap_size_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         kind_ff       <= kind_in;
      end
      size_ff       <= size_in;
      align_ff      <= align_in;
      faddr_ff      <= faddr_in;
      tmp_ff        <= tmp_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      prv_ff        <= prv_in;
      nx_ff         <= nx_in;
      ent_ff        <= ent_in;
      pent_ff       <= pent_in;
      nent_ff       <= nent_in;
      addr_ff       <= addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rd_idx_ff     <= rd_addr;
      vld_rd_ff     <= vld_ff[rd_addr];
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_addr = rsp_addr_ff;
   assign rsp_status     = rsp_status_ff;
   assign pready         = 1'b1;
   assign prdata         = (paddr[2] == CSR_HEAP_SIZE) ? heap_size_ff : heap_base_ff;

   // an accepted item raises busy
   `FFHA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                     "accepted item did not raise busy")
   // a result only closes a busy period
   `FFHA_ASSERT_SAME(a_rsp_ends_busy, clock, reset, rsp_valid, !busy && $past(busy),
                     "result without a preceding busy period")
   // failed requests report a zero address
   `FFHA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_status != STS_OK,
                     rsp_alloc_addr == '0, "failed request with nonzero address")
   // free requests report a zero address
   `FFHA_ASSERT_SAME(a_free_zero, clock, reset, rsp_valid && kind_ff == REQ_FREE,
                     rsp_alloc_addr == '0, "free request with nonzero address")

endmodule

`default_nettype wire

### rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/ffha_rem.sv
// ----------------------------------------------------------------------------
// ffha_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_rem (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffha_pkg::rem_req_type req,
   output ffha_pkg::rem_rsp_type     rsp
);
   import ffha_pkg::*;

   localparam int CNT_W = $clog2(SIZE_W) + 1;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SIZE_W-1:0]    dvd_ff, dvd_in;
   logic [ALIGN_W-1:0]   dvs_ff, dvs_in;
   logic [ALIGN_W-1:0]   rem_ff, rem_in;
   logic [ALIGN_W:0]     shifted;
   logic [ALIGN_W+1:0]   diff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, dvd_ff[SIZE_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = req.dividend;
         dvs_in = req.divisor;
         rem_in = '0;
      end else if (run_ff) begin
         // trial subtract, keep it when no borrow
         rem_in = diff[ALIGN_W+1] ? shifted[ALIGN_W-1:0] : diff[ALIGN_W-1:0];
         dvd_in = {dvd_ff[SIZE_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SIZE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

`default_nettype wire

### rtl/ffha_alu.sv
// ----------------------------------------------------------------------------
// ffha_alu
// shared add / subtract unit, borrow flag serves as unsigned less-than
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_alu #(
   parameter int W = 33
) (
   input  wire ffha_pkg::alu_op_type op,
   input  wire logic [W-1:0]         a,
   input  wire logic [W-1:0]         b,
   output logic      [W-1:0]         res,
   output logic                      borrow
);
   import ffha_pkg::*;

   logic [W:0] full;

   always_comb begin
      unique case (op)
         ALU_ADD: full = {1'b0, a} + {1'b0, b};
         ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default: full = '0;
      endcase
      res    = full[W-1:0];
      borrow = (op == ALU_SUB) && full[W];
   end

endmodule

`default_nettype wire

### verif/first_fit_heap_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// self-checking bench for the first-fit heap allocator: a cycle-free
// predictor of the descriptor pool runs beside the block, every result is
// compared with the oldest prediction, and directed cases are followed by
// random alloc/free traffic under several heap settings
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int POOL      = DESCRIPTORS_DEF;
   localparam int NO_ENTRY  = POOL;
   localparam int WATCHDOG  = 20000;
   localparam int DRAIN_GAP = 40;
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEAP_BASE = {CSR_HEAP_BASE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEAP_SIZE = {CSR_HEAP_SIZE, 2'b00};

   typedef struct {
      logic [SIZE_W-1:0] addr;
      status_type        status;
   } alloc_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_type = REQ_ALLOC;
   logic [SIZE_W-1:0]     req_size = '0;
   logic [ALIGN_W-1:0]    req_align = 17'd1;
   logic [SIZE_W-1:0]     req_free_addr = '0;
   logic                  rsp_valid;
   logic [SIZE_W-1:0]     rsp_alloc_addr;
   logic [1:0]            rsp_status;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   first_fit_heap_allocator i_dut (
      .clock, .reset, .start, .busy, .req_type, .req_size, .req_align,
      .req_free_addr, .rsp_valid, .rsp_alloc_addr, .rsp_status,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor: a copy of the descriptor pool with free, outstanding and
   // spare chains, updated once per accepted item
   // ---------------------------------------------------------------------
   logic [31:0]  cfg_base, cfg_size;
   logic [31:0]  pool_base [POOL];
   logic [31:0]  pool_size [POOL];
   int unsigned  pool_link [POOL];
   int unsigned  free_chain, busy_chain, spare_chain;

   alloc_result_t pending_results [$];
   bit            failed;
   bit            bursty;

   function automatic bit is_entry(int unsigned i);
      return i < POOL;
   endfunction

   function automatic void pool_init();
      for (int i = 0; i < POOL; i++) begin
         pool_base[i] = '0;
         pool_size[i] = '0;
         pool_link[i] = i + 1;
      end
      busy_chain = NO_ENTRY;
      // an empty heap leaves entry 0 on the spare chain
      if (cfg_size == 0) begin
         free_chain  = NO_ENTRY;
         spare_chain = 0;
      end else begin
         pool_base[0] = cfg_base;
         pool_size[0] = cfg_size;
         pool_link[0] = NO_ENTRY;
         free_chain   = 0;
         spare_chain  = 1;
      end
   endfunction

   function automatic void spare_return(int unsigned i);
      pool_base[i] = '0;
      pool_size[i] = '0;
      pool_link[i] = spare_chain;
      spare_chain  = i;
   endfunction

   // merge neighbors whose end meets the next base (wrapping at 2^32)
   function automatic void free_merge();
      int unsigned cur, nx, steps;
      cur   = free_chain;
      steps = 0;
      while (is_entry(cur) && is_entry(pool_link[cur]) && steps <= POOL) begin
         nx = pool_link[cur];
         steps++;
         if (pool_base[cur] + pool_size[cur] == pool_base[nx]) begin
            pool_size[cur] += pool_size[nx];
            pool_link[cur]  = pool_link[nx];
            spare_return(nx);
         end else begin
            cur = nx;
         end
      end
   endfunction

   function automatic alloc_result_t heap_alloc(logic [31:0] size, logic [16:0] align);
      alloc_result_t r;
      logic [63:0]   a, rem, need;
      int unsigned   prev, f, s, steps;
      r.addr   = '0;
      r.status = STS_NO_FIT;
      a    = (align == 0) ? 64'd1 : 64'(align);
      rem  = 64'(size) % a;
      need = 64'(size) + ((rem != 0) ? a - rem : 64'd0);
      if (need == 0) return r;
      prev  = NO_ENTRY;
      f     = free_chain;
      steps = 0;
      while (is_entry(f) && steps <= POOL) begin
         if (64'(pool_size[f]) >= need) break;
         prev = f;
         f    = pool_link[f];
         steps++;
      end
      if (!is_entry(f) || 64'(pool_size[f]) < need) return r;
      // fit first, then descriptor, even for an exact fit
      if (!is_entry(spare_chain)) begin
         r.status = STS_NO_DESC;
         return r;
      end
      s            = spare_chain;
      spare_chain  = pool_link[s];
      pool_base[s] = pool_base[f];
      pool_size[s] = need[31:0];
      pool_link[s] = busy_chain;
      busy_chain   = s;
      r.addr       = pool_base[f];
      r.status     = STS_OK;
      pool_base[f] = pool_base[f] + need[31:0];
      pool_size[f] = pool_size[f] - need[31:0];
      if (pool_size[f] == 0) begin
         if (is_entry(prev)) pool_link[prev] = pool_link[f];
         else free_chain = pool_link[f];
         spare_return(f);
      end
      return r;
   endfunction

   function automatic alloc_result_t heap_release(logic [31:0] addr);
      alloc_result_t r;
      int unsigned   prev, cur, p, c, steps;
      r.addr   = '0;
      r.status = STS_UNKNOWN;
      prev  = NO_ENTRY;
      cur   = busy_chain;
      steps = 0;
      while (is_entry(cur) && steps <= POOL) begin
         if (pool_base[cur] == addr) break;
         prev = cur;
         cur  = pool_link[cur];
         steps++;
      end
      if (!is_entry(cur) || pool_base[cur] != addr) return r;
      if (is_entry(prev)) pool_link[prev] = pool_link[cur];
      else busy_chain = pool_link[cur];
      // insert in address order
      p     = NO_ENTRY;
      c     = free_chain;
      steps = 0;
      while (is_entry(c) && pool_base[c] < pool_base[cur] && steps <= POOL) begin
         p = c;
         c = pool_link[c];
         steps++;
      end
      pool_link[cur] = c;
      if (is_entry(p)) pool_link[p] = cur;
      else free_chain = cur;
      free_merge();
      r.status = STS_OK;
      return r;
   endfunction

   // pick the base of a live block, or a random address if none is live
   function automatic logic [31:0] live_block_addr();
      logic [31:0] bases [$];
      int unsigned cur, steps;
      cur   = busy_chain;
      steps = 0;
      while (is_entry(cur) && steps <= POOL) begin
         bases.push_back(pool_base[cur]);
         cur = pool_link[cur];
         steps++;
      end
      if (bases.size() == 0) return $urandom;
      return bases[$urandom_range(0, bases.size() - 1)];
   endfunction

   // ---------------------------------------------------------------------
   // result checker: one result per item, in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_t exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: addr %h status %0d",
                   rsp_alloc_addr, rsp_status);
            failed = 1'b1;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_alloc_addr !== exp_r.addr) begin
               $error("alloc_addr expected %h got %h", exp_r.addr, rsp_alloc_addr);
               failed = 1'b1;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d got %0d", exp_r.status, rsp_status);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // drivers; inputs move on the falling edge
   // ---------------------------------------------------------------------
   function automatic int unsigned draw_gap();
      if ($urandom_range(0, 49) == 0) bursty = !bursty;
      return bursty ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic req_idle();
      @(negedge clock);
      start = 1'b0;
   endtask

   // sends one item; start stays high after acceptance until the next call
   task automatic send_item(req_kind_type kind, logic [31:0] size,
                            logic [16:0] align, logic [31:0] addr);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_idle();
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start         = 1'b1;
      req_type      = kind;
      req_size      = size;
      req_align     = align;
      req_free_addr = addr;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      if (kind == REQ_ALLOC) pending_results.push_back(heap_alloc(size, align));
      else pending_results.push_back(heap_release(addr));
   endtask

   task automatic wait_idle();
      req_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // register write; the pool is rebuilt by either register
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      if (addr == ADDR_HEAP_BASE) cfg_base = value;
      else cfg_size = value;
      pool_init();
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_heap(logic [31:0] base, logic [31:0] size);
      wait_idle();
      csr_write(ADDR_HEAP_BASE, base);
      csr_write(ADDR_HEAP_SIZE, size);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // out of reset the heap is empty
   task automatic test_empty_heap();
      send_item(REQ_ALLOC, 32'd16, 17'd1, '0);
      send_item(REQ_ALLOC, 32'd0, 17'd1, '0);
      send_item(REQ_FREE, '0, 17'd1, 32'd0);
   endtask

   task automatic test_rounding_and_merge();
      logic [31:0] a0, a1, a2;
      set_heap(32'h0000_1000, 32'h0000_1000);
      send_item(REQ_ALLOC, 32'd0, 17'd8, '0);               // zero size
      send_item(REQ_ALLOC, 32'd5, 17'd0, '0);               // zero align
      a0 = pool_base[busy_chain];
      send_item(REQ_ALLOC, 32'd1, 17'h10000, '0);           // largest power-of-two align
      send_item(REQ_ALLOC, 32'd3, 17'd8, '0);
      a1 = pool_base[busy_chain];
      send_item(REQ_ALLOC, 32'hFFFF_FFFF, 17'h1FFFF, '0);   // too large
      send_item(REQ_ALLOC, 32'd20, 17'd16, '0);
      a2 = pool_base[busy_chain];
      send_item(REQ_FREE, 32'hFFFF_FFFF, 17'h1FFFF, 32'h0000_1003); // unknown
      send_item(REQ_FREE, '0, 17'd1, a1);
      send_item(REQ_FREE, '0, 17'd1, a1);                   // double free
      send_item(REQ_FREE, '0, 17'd1, a0);
      send_item(REQ_FREE, '0, 17'd1, a2);                   // merges back
      send_item(REQ_ALLOC, 32'h1000, 17'd1, '0);            // exact fit
      send_item(REQ_ALLOC, 32'd1, 17'd1, '0);               // nothing free
      send_item(REQ_FREE, '0, 17'd1, 32'h0000_1000);        // into empty list
   endtask

   // addresses run through 2^32
   task automatic test_address_wrap();
      set_heap(32'hFFFF_FFF0, 32'h0000_0040);
      send_item(REQ_ALLOC, 32'd16, 17'd1, '0);
      send_item(REQ_ALLOC, 32'd16, 17'd1, '0);
      send_item(REQ_ALLOC, 32'd16, 17'd1, '0);
      send_item(REQ_FREE, '0, 17'd1, 32'h0000_0000);
      send_item(REQ_FREE, '0, 17'd1, 32'hFFFF_FFF0);
      send_item(REQ_ALLOC, 32'd48, 17'd1, '0);
   endtask

   // run the descriptor pool dry
   task automatic test_descriptor_limit();
      set_heap(32'h0, 32'hFFFF_FFFF);
      for (int i = 0; i < POOL + 2; i++) send_item(REQ_ALLOC, 32'd8, 17'd4, '0);
      for (int i = 0; i < 4; i++) send_item(REQ_FREE, '0, 17'd1, live_block_addr());
   endtask

   // mostly live alloc/free traffic, some noise
   task automatic test_random_traffic(logic [31:0] base, logic [31:0] size, int items);
      logic [31:0] max_req;
      int unsigned pick;
      set_heap(base, size);
      max_req = (size >> 4) < 2 ? 32'd2 : size >> 4;
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send_item(REQ_ALLOC, $urandom_range(0, max_req),
                      17'(1 << $urandom_range(0, 5)), $urandom);
         else if (pick < 88)
            send_item(REQ_FREE, $urandom, 17'($urandom), live_block_addr());
         else if (pick < 94)
            send_item(REQ_ALLOC, $urandom, 17'($urandom), $urandom);
         else
            send_item(REQ_FREE, $urandom, 17'($urandom), $urandom);
      end
   endtask

   initial begin
      failed    = 1'b0;
      bursty    = 1'b0;
      cfg_base  = '0;
      cfg_size  = '0;
      pool_init();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_heap();
      test_rounding_and_merge();
      test_address_wrap();
      test_descriptor_limit();
      test_random_traffic(32'h0000_0000, 32'h0000_1000, 250);
      test_random_traffic(32'hFFFF_FFFF, 32'h0000_0001, 100);
      test_random_traffic($urandom, $urandom_range(32'h100, 32'h10000), 300);
      test_random_traffic(32'hFFFF_F000, 32'hFFFF_FFFF, 300);
      test_random_traffic($urandom, $urandom, 300);

      wait_idle();
      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
